### rtl/mmf_pkg.sv
// ----------------------------------------------------------------------------
// mmf_pkg
// Shared constants, types and helpers for the fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mmf_pkg;

  localparam int MAX_DIM     = 8;
  localparam int ELEM_WIDTH  = 16;
  localparam int PRODUCT_W   = 35;
  localparam int DIM_W       = 4;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int MUL_W       = 2 * ELEM_WIDTH;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

  // Configuration register indexes
  localparam logic [1:0] CFG_ROWS_OF_A       = 2'd0;
  localparam logic [1:0] CFG_INNER_DIMENSION = 2'd1;
  localparam logic [1:0] CFG_COLS_OF_B       = 2'd2;

  // Tag that travels with each multiply-accumulate term
  typedef struct packed {
    logic             first;      // first term of a dot product
    logic             last_term;  // last term of a dot product
    logic             final_elem; // last term of the whole product matrix
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mmf_tag_t;

  // Out-of-range dimensions: zero acts as one, above MAX_DIM acts as MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] res;
    res = d;
    if (d == '0) begin
      res = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/mmf_ram.sv
// ----------------------------------------------------------------------------
// mmf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds when rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/mmf_mac.sv
// ----------------------------------------------------------------------------
// mmf_mac
// Multiply stage, accumulator and result register of the product pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module mmf_mac (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  adv,
  input  wire logic                                  s1_valid,
  input  wire mmf_pkg::mmf_tag_t                     s1_tag,
  input  wire logic signed [mmf_pkg::ELEM_WIDTH-1:0] a_data,
  input  wire logic signed [mmf_pkg::ELEM_WIDTH-1:0] b_data,
  output logic                                       out_valid,
  output logic signed [mmf_pkg::PRODUCT_W-1:0]       out_product_value,
  output logic        [mmf_pkg::IDX_W-1:0]           out_row_index,
  output logic        [mmf_pkg::IDX_W-1:0]           out_col_index,
  output logic                                       out_last
);

  logic                                   s2_valid_r;
  mmf_pkg::mmf_tag_t                      s2_tag_r;
  logic signed [mmf_pkg::MUL_W-1:0]       mul_r;
  logic signed [mmf_pkg::PRODUCT_W-1:0]   acc_r;
  logic signed [mmf_pkg::PRODUCT_W-1:0]   mul_ext;
  logic signed [mmf_pkg::PRODUCT_W-1:0]   acc_sum;
  logic                                   out_valid_r;
  logic signed [mmf_pkg::PRODUCT_W-1:0]   out_value_r;
  logic        [mmf_pkg::IDX_W-1:0]       out_row_r;
  logic        [mmf_pkg::IDX_W-1:0]       out_col_r;
  logic                                   out_last_r;

  // Sign extend the product to the result width
  assign mul_ext = mmf_pkg::PRODUCT_W'(mul_r);
  assign acc_sum = s2_tag_r.first ? mul_ext : acc_r + mul_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r  <= s1_valid;
      out_valid_r <= s2_valid_r && s2_tag_r.last_term;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tag_r <= s1_tag;
      mul_r    <= a_data * b_data;
      if (s2_valid_r) begin
        acc_r <= acc_sum;
        if (s2_tag_r.last_term) begin
          out_value_r <= acc_sum;
          out_row_r   <= s2_tag_r.row;
          out_col_r   <= s2_tag_r.col;
          out_last_r  <= s2_tag_r.final_elem;
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product_value = out_value_r;
  assign out_row_index     = out_row_r;
  assign out_col_index     = out_col_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

### rtl/matrix_multiply_fixed.sv
// ----------------------------------------------------------------------------
// matrix_multiply_fixed
// Fixed-point C = A * B with both operands held in on-chip RAM.
// ----------------------------------------------------------------------------
// Elements stream in one per transfer, all of A row-major, then all of B
// row-major, at one element per cycle while in_ready is high. The transfer
// carrying the last element of B starts the product phase: one shared
// multiply-accumulate walks the two stores, one term per cycle while the
// output is not stalled, limited by the single read port of each store.
// Results leave row-major with row and column tags, out_last on the final
// element; an output stall freezes the product pipeline. Input is not taken
// during the product phase, but loading of the next A starts as soon as the
// last term is issued, even while results still drain. Dimension registers
// are sampled at each input transfer and latched for the product phase; 0
// acts as 1 and values above 8 act as 8. Results are exact Q.16 sums, no
// rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_fixed (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input element channel
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [mmf_pkg::ELEM_WIDTH-1:0] in_element_value,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [mmf_pkg::PRODUCT_W-1:0]       out_product_value,
  output logic        [mmf_pkg::IDX_W-1:0]           out_row_index,
  output logic        [mmf_pkg::IDX_W-1:0]           out_col_index,
  output logic                                       out_last,
  // configuration write channel
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [1:0]                            cfg_index,
  input  wire logic [mmf_pkg::DIM_W-1:0]             cfg_data
);

  localparam int AW = mmf_pkg::ADDR_W;
  localparam int IW = mmf_pkg::IDX_W;
  localparam int CW = mmf_pkg::CNT_W;
  localparam int DW = mmf_pkg::DIM_W;

  typedef enum logic [1:0] {ST_LOAD_A, ST_LOAD_B, ST_COMPUTE} state_t;

  state_t          state_r;
  logic [DW-1:0]   rows_r, inner_r, cols_r;
  logic [CW-1:0]   load_count_r;

  // latched job geometry
  logic [IW-1:0]   m_last_r, k_last_r, n_last_r;
  logic [AW-1:0]   k_step_r, n_step_r;

  // issue pointers
  logic [IW-1:0]   r_r, c_r, i_r;
  logic [AW-1:0]   a_base_r, a_addr_r, b_addr_r;
  logic [IW-1:0]   r_nxt, c_nxt, i_nxt;
  logic [AW-1:0]   a_base_nxt, a_addr_nxt, b_addr_nxt;

  logic            s1_valid_r;
  mmf_pkg::mmf_tag_t s1_tag_r, issue_tag;

  logic [DW-1:0]   m_cl, k_cl, n_cl;
  logic [CW-1:0]   cnt_inc, size_a, size_b;
  logic            in_xfer, busy, adv, issue;
  logic            wr_a, wr_b, a_full, b_full;
  logic            term_last, col_last, row_last;
  logic [mmf_pkg::ELEM_WIDTH-1:0] rd_a, rd_b;

  // --------------------------------------------------------------------------
  // Configuration: always ready, writes beyond the list are dropped
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= mmf_pkg::DIM_RESET;
      inner_r <= mmf_pkg::DIM_RESET;
      cols_r  <= mmf_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mmf_pkg::CFG_ROWS_OF_A:       rows_r  <= cfg_data;
        mmf_pkg::CFG_INNER_DIMENSION: inner_r <= cfg_data;
        mmf_pkg::CFG_COLS_OF_B:       cols_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Load side
  // --------------------------------------------------------------------------
  assign m_cl    = mmf_pkg::clamp_dim(rows_r);
  assign k_cl    = mmf_pkg::clamp_dim(inner_r);
  assign n_cl    = mmf_pkg::clamp_dim(cols_r);
  assign size_a  = CW'(m_cl) * CW'(k_cl);
  assign size_b  = CW'(k_cl) * CW'(n_cl);
  assign cnt_inc = load_count_r + CW'(1);
  assign a_full  = cnt_inc >= size_a;
  assign b_full  = cnt_inc >= size_b;

  assign busy     = (state_r == ST_COMPUTE);
  assign in_ready = !busy;
  assign in_xfer  = in_valid && in_ready;
  assign wr_a     = in_xfer && (state_r == ST_LOAD_A);
  assign wr_b     = in_xfer && (state_r == ST_LOAD_B);

  // --------------------------------------------------------------------------
  // Issue side: one (r, c, i) term per cycle while the output is not stalled
  // --------------------------------------------------------------------------
  assign adv   = !out_valid || out_ready;
  assign issue = busy && adv;

  assign term_last = (i_r == k_last_r);
  assign col_last  = (c_r == n_last_r);
  assign row_last  = (r_r == m_last_r);

  always_comb begin
    issue_tag.first      = (i_r == '0);
    issue_tag.last_term  = term_last;
    issue_tag.final_elem = term_last && col_last && row_last;
    issue_tag.row        = r_r;
    issue_tag.col        = c_r;
  end

  always_comb begin
    r_nxt      = r_r;
    c_nxt      = c_r;
    i_nxt      = i_r + IW'(1);
    a_base_nxt = a_base_r;
    a_addr_nxt = a_addr_r + AW'(1);
    b_addr_nxt = b_addr_r + n_step_r;
    if (term_last) begin
      i_nxt = '0;
      if (col_last) begin
        c_nxt      = '0;
        r_nxt      = r_r + IW'(1);
        a_base_nxt = a_base_r + k_step_r;
        a_addr_nxt = a_base_r + k_step_r;
        b_addr_nxt = '0;
      end else begin
        c_nxt      = c_r + IW'(1);
        a_addr_nxt = a_base_r;
        b_addr_nxt = AW'(c_r) + AW'(1);
      end
    end
  end

  // State, load counter and issue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD_A;
      load_count_r <= '0;
    end else begin
      unique case (state_r)
        ST_LOAD_A: begin
          if (in_xfer) begin
            load_count_r <= a_full ? '0 : cnt_inc;
            if (a_full) begin
              state_r <= ST_LOAD_B;
            end
          end
        end
        ST_LOAD_B: begin
          if (in_xfer) begin
            load_count_r <= b_full ? '0 : cnt_inc;
            if (b_full) begin
              state_r  <= ST_COMPUTE;
              m_last_r <= IW'(m_cl - DW'(1));
              k_last_r <= IW'(k_cl - DW'(1));
              n_last_r <= IW'(n_cl - DW'(1));
              k_step_r <= AW'(k_cl);
              n_step_r <= AW'(n_cl);
              r_r      <= '0;
              c_r      <= '0;
              i_r      <= '0;
              a_base_r <= '0;
              a_addr_r <= '0;
              b_addr_r <= '0;
            end
          end
        end
        ST_COMPUTE: begin
          if (issue) begin
            r_r      <= r_nxt;
            c_r      <= c_nxt;
            i_r      <= i_nxt;
            a_base_r <= a_base_nxt;
            a_addr_r <= a_addr_nxt;
            b_addr_r <= b_addr_nxt;
            if (issue_tag.final_elem) begin
              state_r <= ST_LOAD_A;
            end
          end
        end
        default: state_r <= ST_LOAD_A;
      endcase
    end
  end

  // Tag stage aligned with the registered RAM read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag_r <= issue_tag;
    end
  end

  // --------------------------------------------------------------------------
  // Operand stores
  // --------------------------------------------------------------------------
  mmf_ram #(
    .WIDTH (mmf_pkg::ELEM_WIDTH),
    .DEPTH (mmf_pkg::STORE_DEPTH)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (load_count_r[AW-1:0]),
    .wr_data (in_element_value),
    .rd_en   (issue),
    .rd_addr (a_addr_r),
    .rd_data (rd_a)
  );

  mmf_ram #(
    .WIDTH (mmf_pkg::ELEM_WIDTH),
    .DEPTH (mmf_pkg::STORE_DEPTH)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (load_count_r[AW-1:0]),
    .wr_data (in_element_value),
    .rd_en   (issue),
    .rd_addr (b_addr_r),
    .rd_data (rd_b)
  );

  // --------------------------------------------------------------------------
  // Multiply-accumulate and result register
  // --------------------------------------------------------------------------
  mmf_mac u_mac (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .s1_valid          (s1_valid_r),
    .s1_tag            (s1_tag_r),
    .a_data            (signed'(rd_a)),
    .b_data            (signed'(rd_b)),
    .out_valid         (out_valid),
    .out_product_value (out_product_value),
    .out_row_index     (out_row_index),
    .out_col_index     (out_col_index),
    .out_last          (out_last)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // incremental A address tracks r*K + i
  a_addr_track: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> a_addr_r == AW'(AW'(r_r) * k_step_r + AW'(i_r)))
    else $error("A read address out of step");

  // incremental B address tracks i*N + c
  b_addr_track: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> b_addr_r == AW'(AW'(i_r) * n_step_r + AW'(c_r)))
    else $error("B read address out of step");

  // issue pointers stay inside the latched geometry
  ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (r_r <= m_last_r && c_r <= n_last_r && i_r <= k_last_r))
    else $error("issue pointer beyond matrix");

  // last B element starts the product phase with a cleared load counter
  b_done_start: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_b && b_full) |=> (busy && load_count_r == '0))
    else $error("product phase did not start");

  // no load counter movement while the stores are being read
  load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(busy) && busy) |-> $stable(load_count_r))
    else $error("load counter moved during product phase");

endmodule

`default_nettype wire

### dv/tb_matrix_multiply_fixed.sv
// ----------------------------------------------------------------------------
// tb_matrix_multiply_fixed
// Self-checking bench for the fixed-point matrix multiplier. Streams A and B
// element by element under random flow control on both channels, predicts
// every product element with exact Q.16 arithmetic and compares each result
// transfer field by field. Dimension registers are changed between jobs and,
// with the block idle, in the middle of a matrix load.
// ----------------------------------------------------------------------------

module tb_matrix_multiply_fixed;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 20;
  localparam int RESET_LEN   = 6;
  localparam int ITEM_TARGET = 370;     // random element transfers
  localparam int SETTLE      = 8;       // above the pipeline latency
  localparam int DRAIN       = 20;
  localparam int LIMIT_NS    = 4000000; // far above worst case

  // Index with no register behind it; a write there must change nothing
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam logic signed [mmf_pkg::ELEM_WIDTH-1:0] ELEM_MIN =
    {1'b1, {(mmf_pkg::ELEM_WIDTH-1){1'b0}}};
  localparam logic signed [mmf_pkg::ELEM_WIDTH-1:0] ELEM_MAX =
    {1'b0, {(mmf_pkg::ELEM_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic signed [mmf_pkg::PRODUCT_W-1:0] value;
    logic [mmf_pkg::IDX_W-1:0]            row;
    logic [mmf_pkg::IDX_W-1:0]            col;
    logic                                 last;
  } product_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic signed [mmf_pkg::ELEM_WIDTH-1:0] in_element_value = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic signed [mmf_pkg::PRODUCT_W-1:0]  out_product_value;
  logic [mmf_pkg::IDX_W-1:0]             out_row_index;
  logic [mmf_pkg::IDX_W-1:0]             out_col_index;
  logic                                  out_last;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [1:0]                            cfg_index = mmf_pkg::CFG_ROWS_OF_A;
  logic [mmf_pkg::DIM_W-1:0]             cfg_data = '0;

  matrix_multiply_fixed u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_product_value (out_product_value),
    .out_row_index     (out_row_index),
    .out_col_index     (out_col_index),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction state: shadow dimension registers, both operand stores, the
  // load position, and the queue of product elements still to arrive.
  // --------------------------------------------------------------------------
  logic [mmf_pkg::DIM_W-1:0]             rows_cfg  = mmf_pkg::DIM_RESET;
  logic [mmf_pkg::DIM_W-1:0]             inner_cfg = mmf_pkg::DIM_RESET;
  logic [mmf_pkg::DIM_W-1:0]             cols_cfg  = mmf_pkg::DIM_RESET;
  logic signed [mmf_pkg::ELEM_WIDTH-1:0] a_mat [mmf_pkg::STORE_DEPTH];
  logic signed [mmf_pkg::ELEM_WIDTH-1:0] b_mat [mmf_pkg::STORE_DEPTH];
  int                                    ld_count = 0;
  logic                                  ld_b_phase = 1'b0;
  product_t                              expected_products [$];

  logic signed [mmf_pkg::ELEM_WIDTH-1:0] elem_q [$];  // elements for the driver
  int                                    items_queued = 0;
  int                                    fail_count = 0;

  // Dimension as the block uses it: zero acts as one, above MAX_DIM saturates
  function automatic int eff_dim(input logic [mmf_pkg::DIM_W-1:0] d);
    if (d == '0) return 1;
    if (int'(d) > mmf_pkg::MAX_DIM) return mmf_pkg::MAX_DIM;
    return int'(d);
  endfunction

  // Absorb one accepted element; the last element of B yields the product
  task automatic predict_products(input logic signed [mmf_pkg::ELEM_WIDTH-1:0] v);
    int m, k, n, r, c, i;
    logic signed [63:0] acc, av, bv;
    product_t p;
    m = eff_dim(rows_cfg);
    k = eff_dim(inner_cfg);
    n = eff_dim(cols_cfg);
    if (!ld_b_phase) begin
      a_mat[ld_count % mmf_pkg::STORE_DEPTH] = v;
      ld_count = (ld_count + 1) % 128;
      // >= : a dimension shrunk mid-load ends the matrix on the next element
      if (ld_count >= m * k) begin
        ld_b_phase = 1'b1;
        ld_count   = 0;
      end
    end else begin
      b_mat[ld_count % mmf_pkg::STORE_DEPTH] = v;
      ld_count = (ld_count + 1) % 128;
      if (ld_count >= k * n) begin
        for (r = 0; r < m; r++) begin
          for (c = 0; c < n; c++) begin
            acc = '0;
            for (i = 0; i < k; i++) begin
              av  = a_mat[(r * k + i) % mmf_pkg::STORE_DEPTH];
              bv  = b_mat[(i * n + c) % mmf_pkg::STORE_DEPTH];
              acc = acc + av * bv;
            end
            p.value = acc[mmf_pkg::PRODUCT_W-1:0];
            p.row   = mmf_pkg::IDX_W'(r);
            p.col   = mmf_pkg::IDX_W'(c);
            p.last  = (r == m - 1) && (c == n - 1);
            expected_products.push_back(p);
          end
        end
        ld_b_phase = 1'b0;
        ld_count   = 0;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver: pops elements from elem_q, random gap before each one with
  // occasional zero-gap bursts. Prediction runs on each accepted transfer.
  // --------------------------------------------------------------------------
  int   in_gap = 0;
  logic in_burst = 1'b0;
  logic in_taken;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        predict_products(in_element_value);
        if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 6);
      end
      // payload may only move once the current transfer is done
      if (in_taken || !in_valid) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (elem_q.size() > 0) begin
          in_valid         <= 1'b1;
          in_element_value <= elem_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compares each result transfer against the oldest predicted
  // element, then draws a random stall.
  // --------------------------------------------------------------------------
  int       out_stall = 0;
  logic     out_burst = 1'b0;
  product_t exp_p;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_products.size() == 0) begin
          $error("unexpected result: product_value %0d row_index %0d col_index %0d",
                 out_product_value, out_row_index, out_col_index);
          fail_count++;
        end else begin
          exp_p = expected_products.pop_front();
          if (out_product_value !== exp_p.value) begin
            $error("product_value: expected %0d, actual %0d",
                   exp_p.value, out_product_value);
            fail_count++;
          end
          if (out_row_index !== exp_p.row) begin
            $error("row_index: expected %0d, actual %0d", exp_p.row, out_row_index);
            fail_count++;
          end
          if (out_col_index !== exp_p.col) begin
            $error("col_index: expected %0d, actual %0d", exp_p.col, out_col_index);
            fail_count++;
          end
          if (out_last !== exp_p.last) begin
            $error("last: expected %0d, actual %0d", exp_p.last, out_last);
            fail_count++;
          end
        end
        if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 6);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [mmf_pkg::ELEM_WIDTH-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2:       return '0;
      3:       return '1;
      default: return mmf_pkg::ELEM_WIDTH'($urandom);
    endcase
  endfunction

  // Mostly small sizes; sometimes the full size, zero, or above the maximum
  function automatic logic [mmf_pkg::DIM_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) begin
      return mmf_pkg::DIM_W'($urandom_range(mmf_pkg::MAX_DIM + 1,
                                            (1 << mmf_pkg::DIM_W) - 1));
    end
    if (sel == 2) return mmf_pkg::DIM_W'(mmf_pkg::MAX_DIM);
    if (sel < 6) return mmf_pkg::DIM_W'($urandom_range(5, mmf_pkg::MAX_DIM - 1));
    return mmf_pkg::DIM_W'($urandom_range(1, 4));
  endfunction

  task automatic push_item(input logic signed [mmf_pkg::ELEM_WIDTH-1:0] v);
    elem_q.push_back(v);
    items_queued++;
  endtask

  task automatic queue_elements(input int count);
    repeat (count) push_item(pick_element());
  endtask

  // Sampled on the falling edge so the clocked blocks have all settled
  task automatic wait_idle(input int settle);
    do @(negedge clk);
    while (elem_q.size() != 0 || in_valid || expected_products.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx,
                           input logic [mmf_pkg::DIM_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mmf_pkg::CFG_ROWS_OF_A:       rows_cfg  = val;
      mmf_pkg::CFG_INNER_DIMENSION: inner_cfg = val;
      mmf_pkg::CFG_COLS_OF_B:       cols_cfg  = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [mmf_pkg::DIM_W-1:0] m,
                           input logic [mmf_pkg::DIM_W-1:0] k,
                           input logic [mmf_pkg::DIM_W-1:0] n);
    write_reg(mmf_pkg::CFG_ROWS_OF_A, m);
    write_reg(mmf_pkg::CFG_INNER_DIMENSION, k);
    write_reg(mmf_pkg::CFG_COLS_OF_B, n);
  endtask

  // With the block idle, queue whatever completes the job in progress under
  // the current registers (at least one element if the size already passed)
  task automatic finish_job();
    int m, k, n, need;
    m = eff_dim(rows_cfg);
    k = eff_dim(inner_cfg);
    n = eff_dim(cols_cfg);
    if (!ld_b_phase) begin
      need = (m * k > ld_count) ? m * k - ld_count : 1;
      queue_elements(need + k * n);
    end else begin
      need = (k * n > ld_count) ? k * n - ld_count : 1;
      queue_elements(need);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int   m, k, n, base, jobs, part;
    logic big_first;

    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 1x1x1: most negative squared, then max times min
    configure(4'd1, 4'd1, 4'd1);
    push_item(ELEM_MIN);
    push_item(ELEM_MIN);
    push_item(ELEM_MAX);
    push_item(ELEM_MIN);
    wait_idle(SETTLE);

    // zero dimensions act as one: 1x2 times 2x1, largest positive sum
    configure(4'd0, 4'd2, 4'd0);
    repeat (4) push_item(ELEM_MIN);
    wait_idle(SETTLE);

    // write to the unused index, then 2x1 times 1x2 to exercise row/col tags
    write_reg(CFG_UNUSED, 4'hF);
    configure(4'd2, 4'd1, 4'd2);
    push_item(ELEM_MAX);
    push_item('1);
    push_item(mmf_pkg::ELEM_WIDTH'(16'h0100));
    push_item(ELEM_MIN);
    wait_idle(SETTLE);

    // A size shrinks below what is already loaded: A ends on the next element
    configure(4'd2, 4'd2, 4'd2);
    queue_elements(3);
    wait_idle(SETTLE);
    write_reg(mmf_pkg::CFG_INNER_DIMENSION, 4'd1);
    finish_job();
    wait_idle(SETTLE);

    // B size changes while B is partly loaded
    configure(4'd1, 4'd2, 4'd2);
    queue_elements(3);
    wait_idle(SETTLE);
    write_reg(mmf_pkg::CFG_COLS_OF_B, 4'd1);
    finish_job();
    wait_idle(SETTLE);

    // Random phases. Each phase starts idle, so this is also where the
    // sender holds off until every expected result has come back.
    base      = items_queued;
    big_first = 1'b1;
    while (items_queued - base < ITEM_TARGET) begin
      if (big_first) begin
        // full 8x8x8, with over-range values that saturate to the maximum
        configure(4'd15, mmf_pkg::DIM_W'(mmf_pkg::MAX_DIM), 4'd9);
        big_first = 1'b0;
      end else begin
        configure(pick_dim(), pick_dim(), pick_dim());
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CFG_UNUSED, mmf_pkg::DIM_W'($urandom));
      end

      jobs = $urandom_range(1, 3);
      repeat (jobs) begin
        if (items_queued - base >= ITEM_TARGET) break;
        m    = eff_dim(rows_cfg);
        k    = eff_dim(inner_cfg);
        n    = eff_dim(cols_cfg);
        part = $urandom_range(0, 5);
        if (part == 0 && m * k > 1) begin
          // partial A, then resize A with the block idle
          wait_idle(SETTLE);
          queue_elements($urandom_range(1, m * k - 1));
          wait_idle(SETTLE);
          if ($urandom_range(0, 1)) write_reg(mmf_pkg::CFG_ROWS_OF_A, pick_dim());
          else                      write_reg(mmf_pkg::CFG_INNER_DIMENSION, pick_dim());
          finish_job();
        end else if (part == 1 && k * n > 1) begin
          // full A plus partial B, then resize the columns of B
          wait_idle(SETTLE);
          queue_elements(m * k + $urandom_range(1, k * n - 1));
          wait_idle(SETTLE);
          write_reg(mmf_pkg::CFG_COLS_OF_B, pick_dim());
          finish_job();
        end else begin
          // back-to-back well-formed job
          queue_elements(m * k + k * n);
        end
      end
      wait_idle(SETTLE);
    end

    wait_idle(DRAIN);
    if (fail_count == 0) begin
      $display("matrix_multiply_fixed test passed");
    end else begin
      $display("matrix_multiply_fixed test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("matrix_multiply_fixed test failed");
    $finish;
  end

endmodule

### filelist.f
rtl/mmf_pkg.sv
rtl/mmf_ram.sv
rtl/mmf_mac.sv
rtl/matrix_multiply_fixed.sv
dv/tb_matrix_multiply_fixed.sv
